// ===== src/sacc_pkg.sv =====
// ----------------------------------------------------------------------------
// sacc_pkg: shared constants and types
// Geometry, opcodes and the command/status bundles between the controller
// and the datapath of the write-through cache.
// ----------------------------------------------------------------------------
`default_nettype none
package sacc_pkg;
  localparam int NUM_SETS      = 128;
  localparam int NUM_WAYS      = 8;
  localparam int LINE_SIZE     = 64;
  localparam int MEM_ADDR_BITS = 20;

  localparam int OFF_W  = $clog2(LINE_SIZE);
  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TAG_W  = MEM_ADDR_BITS - OFF_W - SET_W;
  localparam int LINE_W = SET_W + WAY_W + OFF_W;

  localparam logic [15:0] LFSR_SEED = 16'd44257;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  typedef struct packed {
    logic load;
    logic lookup;
    logic data_rd;
    logic use_fill;
    logic capture;
    logic fill_start;
    logic fill_step;
    logic tag_wr;
    logic mem_wr;
    logic advance;
    logic emit;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       found;
    logic       last;
    logic       fill_done;
    logic       clr_done;
    logic       out_free;
  } sts_t;
endpackage
`default_nettype wire

// ===== src/sacc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacc_ctrl: cache controller
// Walks one item byte by byte: lookup, hit access or line fill, response.
// ----------------------------------------------------------------------------
`default_nettype none
module sacc_ctrl (
  input  wire           clk,
  input  wire           rst,
  input  wire           s_tvalid,
  output logic          s_tready,
  input  sacc_pkg::sts_t sts,
  output sacc_pkg::cmd_t cmd
);
  import sacc_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_DRD   = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.op inside {OP_READ, OP_WRITE, OP_LOAD}) begin
          cmd.lookup = 1'b1;
          state_next = S_CMP;
        end else begin
          state_next = S_RESP;
        end
      end
      S_CMP: begin
        if (sts.op == OP_READ) begin
          if (sts.found) begin
            cmd.data_rd = 1'b1;
            state_next  = S_DRD;
          end else begin
            cmd.fill_start = 1'b1;
            state_next     = S_FILL;
          end
        end else begin
          cmd.mem_wr  = 1'b1;
          cmd.advance = 1'b1;
          state_next  = sts.last ? S_RESP : S_LOOK;
        end
      end
      S_DRD: begin
        cmd.capture = 1'b1;
        cmd.advance = 1'b1;
        state_next  = sts.last ? S_RESP : S_LOOK;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.tag_wr   = 1'b1;
        cmd.data_rd  = 1'b1;
        cmd.use_fill = 1'b1;
        state_next   = S_DRD;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

`ifndef SYNTHESIS
  a_fill_read_only: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |-> sts.op == OP_READ) else $error("fill outside a read");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == S_LOOK) else $error("accept did not start work");
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mem_wr, cmd.fill_step, cmd.clr_step, cmd.tag_wr}))
    else $error("conflicting memory writes");
`endif
endmodule
`default_nettype wire

// ===== src/sacc_dp.sv =====
// ----------------------------------------------------------------------------
// sacc_dp: cache datapath
// Tag, valid, line and main memories, item registers, LFSR, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module sacc_dp (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  [63:0]                         s_tdata,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [39:0]                         m_tdata,
  input  sacc_pkg::cmd_t                      cmd,
  output sacc_pkg::sts_t                      sts
);
  import sacc_pkg::*;

  logic [7:0]            main_mem [2**MEM_ADDR_BITS];
  logic [7:0]            line_mem [2**LINE_W];
  logic [NUM_WAYS-1:0][TAG_W-1:0] tag_mem [NUM_SETS];
  logic [NUM_WAYS-1:0]   valid_mem [NUM_SETS];

  logic [1:0]               op;
  logic [MEM_ADDR_BITS-1:0] cur;
  logic [1:0]               idx, idx_last;
  logic [31:0]              wdata, rdata;
  logic                     hit;
  logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row;
  logic [NUM_WAYS-1:0]      valid_row;
  logic [15:0]              lfsr, lfsr_next;
  logic [WAY_W-1:0]         fill_way, found_way, rd_way;
  logic                     found;
  logic [OFF_W:0]           fill_cnt;
  logic [SET_W-1:0]         clr_cnt;
  logic [7:0]               mem_q, line_q;
  logic [2:0]               len_in;

  logic [OFF_W-1:0] cur_off;
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;
  assign cur_off = cur[OFF_W-1:0];
  assign cur_set = cur[OFF_W +: SET_W];
  assign cur_tag = cur[MEM_ADDR_BITS-1 -: TAG_W];

  always_comb begin
    found     = 1'b0;
    found_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (valid_row[w] && tag_row[w] == cur_tag) begin
        found     = 1'b1;
        found_way = WAY_W'(w);
      end
    end
  end

  assign lfsr_next = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
  assign rd_way    = cmd.use_fill ? fill_way : found_way;
  assign len_in    = s_tdata[24:22];

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr     <= LFSR_SEED;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      fill_cnt <= '0;
    end else begin
      if (cmd.clr_step) begin
        valid_mem[clr_cnt] <= '0;
        clr_cnt            <= clr_cnt + 1'b1;
      end
      if (cmd.fill_start) begin
        lfsr     <= lfsr_next;
        fill_way <= lfsr_next[WAY_W-1:0];
        fill_cnt <= '0;
        hit      <= 1'b0;
      end
      if (cmd.fill_step) begin
        if (!fill_cnt[OFF_W])
          mem_q <= main_mem[{cur[MEM_ADDR_BITS-1:OFF_W], fill_cnt[OFF_W-1:0]}];
        if (fill_cnt != '0)
          line_mem[{cur_set, fill_way, OFF_W'(fill_cnt - 1'b1)}] <= mem_q;
        fill_cnt <= fill_cnt + 1'b1;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {7'd0, hit, rdata};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.load) begin
        op       <= s_tdata[1:0];
        cur      <= s_tdata[21:2];
        wdata    <= s_tdata[56:25];
        rdata    <= '0;
        hit      <= (s_tdata[1:0] == OP_READ || s_tdata[1:0] == OP_WRITE);
        idx      <= '0;
        idx_last <= (len_in == 3'd0) ? 2'd0 : (len_in > 3'd4) ? 2'd3 : 2'(len_in - 3'd1);
      end
      if (cmd.lookup) begin
        tag_row   <= tag_mem[cur_set];
        valid_row <= valid_mem[cur_set];
      end
      if (cmd.data_rd) line_q <= line_mem[{cur_set, rd_way, cur_off}];
      if (cmd.capture) rdata[8*idx +: 8] <= line_q;
      if (cmd.mem_wr) begin
        main_mem[cur] <= wdata[7:0];
        if (op == OP_WRITE) begin
          if (found) line_mem[{cur_set, found_way, cur_off}] <= wdata[7:0];
          else       hit <= 1'b0;
        end
      end
      if (cmd.tag_wr) begin
        tag_mem[cur_set][fill_way]   <= cur_tag;
        valid_mem[cur_set][fill_way] <= 1'b1;
      end
      if (cmd.advance) begin
        cur   <= cur + 1'b1;
        idx   <= idx + 1'b1;
        wdata <= wdata >> 8;
      end
    end
  end

  assign sts.op        = op;
  assign sts.found     = found;
  assign sts.last      = (idx == idx_last);
  assign sts.fill_done = fill_cnt[OFF_W];
  assign sts.clr_done  = (clr_cnt == SET_W'(NUM_SETS - 1));
  assign sts.out_free  = !m_tvalid || m_tready;
endmodule
`default_nettype wire

// ===== src/set_assoc_write_through_cache.sv =====
// ----------------------------------------------------------------------------
// set_assoc_write_through_cache: 8-way write-through cache with main memory
// Reads fill missing lines from the internal memory; writes go through and
// update hit lines only; direct loads write memory alone.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | op, addr, len, wdata
//  m_*     | out | m_tvalid/m_tready  | rdata, hit
//
//  Each item takes an accept step and a response step around its bytes.
//  Bytes are handled one per step: a hit byte passes tag read, compare plus
//  data read and capture, a write or load byte tag read and compare plus write.
//  A read miss adds a line fill through the single memory port, byte by byte.
//  After reset a sweep clears the valid bits of all 128 sets; no transfer is taken.
//  A finished result sits in the output register; the next transfer is
//  taken while it waits, and a stalled output holds the last step only.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_write_through_cache (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // op[1:0], addr[21:2], len[24:22], wdata[56:25]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata    // rdata[31:0], hit[32]
);
  import sacc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sacc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );
endmodule
`default_nettype wire
